// ===== sv/sjis_pkg.sv =====
// Shared types and constants for the Shift-JIS to JIS stream converter.
// Used by the front classifier, the command queue and the byte sequencer.
// Depends on nothing.
package sjis_pkg;

    // Byte values of the escape sequences.
    localparam logic [7:0] EscByte      = 8'h1B;
    localparam logic [7:0] EnterByte1   = 8'h24;
    localparam logic [7:0] EnterByte2   = 8'h42;
    localparam logic [7:0] LeaveByte1   = 8'h28;
    localparam logic [7:0] LeaveByte2   = 8'h4A;

    // Longest run of output bytes that one input byte can cause.
    localparam int MaxRun = 8;

    // Escape that is sent ahead of the data bytes of a command.
    typedef logic [1:0] t_pre;
    localparam t_pre PRE_NONE  = 2'd0;
    localparam t_pre PRE_ENTER = 2'd1;
    localparam t_pre PRE_LEAVE = 2'd2;

    // One classified input byte: an optional leading escape, zero to two
    // data bytes, and an optional closing escape for end of text.
    typedef struct packed {
        t_pre       pre;
        logic [1:0] n_data;
        logic [7:0] data0;
        logic [7:0] data1;
        logic       post_leave;
    } t_cmd;

    // Full-width JIS pairs for the half-width kana 0xA0..0xDF, indexed by
    // the low six bits of the byte minus 0xA0.
    localparam logic [15:0] KanaTab [64] = '{
        16'h2121, 16'h2123, 16'h2156, 16'h2157, 16'h2122, 16'h2126,
        16'h2572, 16'h2521, 16'h2523, 16'h2525, 16'h2527, 16'h2529,
        16'h2563, 16'h2565, 16'h2567, 16'h2543, 16'h213c, 16'h2522,
        16'h2524, 16'h2526, 16'h2528, 16'h252a, 16'h252b, 16'h252d,
        16'h252f, 16'h2531, 16'h2533, 16'h2535, 16'h2537, 16'h2539,
        16'h253b, 16'h253d, 16'h253f, 16'h2541, 16'h2544, 16'h2546,
        16'h2548, 16'h254a, 16'h254b, 16'h254c, 16'h254d, 16'h254e,
        16'h254f, 16'h2552, 16'h2555, 16'h2558, 16'h255b, 16'h255e,
        16'h255f, 16'h2560, 16'h2561, 16'h2562, 16'h2564, 16'h2566,
        16'h2568, 16'h2569, 16'h256a, 16'h256b, 16'h256c, 16'h256d,
        16'h256f, 16'h2573, 16'h212b, 16'h212c
    };

endpackage

// ===== sv/sjis_front.sv =====
// Front classifier: tracks JIS mode and the held lead byte, and turns each
// accepted input byte into at most one command for the back sequencer.
// Depends on sjis_pkg.
module sjis_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_text,
    output logic              o_push,
    output sjis_pkg::t_cmd    o_cmd
);

    logic       r_jis;
    logic       r_held_valid;
    logic [7:0] r_held_lead;
    logic       n_jis;
    logic       n_held_valid;
    logic [7:0] n_held_lead;

    logic       is_lead;
    logic       is_trail;
    logic       is_kana;
    logic [7:0] lead_sub;
    logic [7:0] hi_base;
    logic [7:0] hi_odd;
    logic [7:0] lo_adj;
    logic [7:0] pair_hi;
    logic [7:0] pair_lo;
    logic [15:0] kana_pair;
    sjis_pkg::t_cmd cmd;

    assign is_lead  = (i_data_byte >= 8'h81 && i_data_byte <= 8'h9F) ||
                      (i_data_byte >= 8'hE0 && i_data_byte <= 8'hFC);
    assign is_trail = (i_data_byte >= 8'h40 && i_data_byte <= 8'h7E) ||
                      (i_data_byte >= 8'h80 && i_data_byte <= 8'hFC);
    assign is_kana  = (i_data_byte >= 8'hA1 && i_data_byte <= 8'hDF);

    // Shift-JIS pair to JIS pair, all arithmetic wrapping in eight bits.
    assign lead_sub = (r_held_lead <= 8'h9F) ? 8'h71 : 8'hB1;
    assign hi_base  = r_held_lead - lead_sub;
    assign hi_odd   = {hi_base[6:0], 1'b1};
    assign lo_adj   = (i_data_byte > 8'h7F) ? (i_data_byte - 8'h01) : i_data_byte;

    always_comb begin
        if (lo_adj >= 8'h9E) begin
            pair_lo = lo_adj - 8'h7D;
            pair_hi = hi_odd + 8'h01;
        end else begin
            pair_lo = lo_adj - 8'h1F;
            pair_hi = hi_odd;
        end
    end

    assign kana_pair = sjis_pkg::KanaTab[i_data_byte[5:0] - 6'h20];

    always_comb begin
        cmd          = '0;
        n_jis        = r_jis;
        n_held_valid = 1'b0;
        n_held_lead  = r_held_lead;

        if (r_held_valid && is_trail) begin
            cmd.pre    = r_jis ? sjis_pkg::PRE_NONE : sjis_pkg::PRE_ENTER;
            cmd.n_data = 2'd2;
            cmd.data0  = pair_hi;
            cmd.data1  = pair_lo;
            n_jis      = 1'b1;
        end else begin
            // A held lead that meets a bad trail is simply forgotten.
            priority if (is_lead) begin
                n_held_valid = 1'b1;
                n_held_lead  = i_data_byte;
            end else if (is_kana) begin
                cmd.pre    = r_jis ? sjis_pkg::PRE_NONE : sjis_pkg::PRE_ENTER;
                cmd.n_data = 2'd2;
                cmd.data0  = kana_pair[15:8];
                cmd.data1  = kana_pair[7:0];
                n_jis      = 1'b1;
            end else if (i_data_byte[7]) begin
                cmd.n_data = 2'd0;
            end else begin
                cmd.pre    = r_jis ? sjis_pkg::PRE_LEAVE : sjis_pkg::PRE_NONE;
                cmd.n_data = 2'd1;
                cmd.data0  = i_data_byte;
                n_jis      = 1'b0;
            end
        end

        if (i_end_of_text) begin
            n_held_valid = 1'b0;
            if (n_jis) begin
                cmd.post_leave = 1'b1;
                n_jis          = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jis        <= 1'b0;
            r_held_valid <= 1'b0;
        end else if (i_accept) begin
            r_jis        <= n_jis;
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held_lead <= n_held_lead;
        end
    end

    // Bytes that cause no output push nothing.
    assign o_push = i_accept && ((cmd.n_data != 2'd0) || cmd.post_leave);
    assign o_cmd  = cmd;

endmodule

// ===== sv/sjis_queue.sv =====
// Short command queue between the front classifier and the back sequencer.
// Depends on sjis_pkg for the command type.
module sjis_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sjis_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_nonempty,
    output sjis_pkg::t_cmd    o_head
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    sjis_pkg::t_cmd  r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full     = (r_count == FullCnt);
    assign o_nonempty = (r_count != '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;
    assign o_head     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/sjis_back.sv =====
// Back sequencer: expands one command into its run of output bytes and
// sends them one per cycle, unless the receiver stalls, through a registered output stage.
// Depends on sjis_pkg.
module sjis_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  sjis_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_last_of_run
);

    logic       r_busy;
    logic [7:0] r_bytes [sjis_pkg::MaxRun];
    logic [3:0] r_len;
    logic [2:0] r_pos;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [7:0] n_bytes [sjis_pkg::MaxRun];
    logic [3:0] n_len;
    logic       advance;
    logic       at_last;
    logic       load;

    // Lay the command out as a flat run of bytes.
    always_comb begin
        for (int k = 0; k < sjis_pkg::MaxRun; k++) begin
            n_bytes[k] = 8'h00;
        end
        n_len = 4'd0;
        if (i_cmd.pre != sjis_pkg::PRE_NONE) begin
            n_bytes[0] = sjis_pkg::EscByte;
            n_bytes[1] = (i_cmd.pre == sjis_pkg::PRE_ENTER) ?
                         sjis_pkg::EnterByte1 : sjis_pkg::LeaveByte1;
            n_bytes[2] = (i_cmd.pre == sjis_pkg::PRE_ENTER) ?
                         sjis_pkg::EnterByte2 : sjis_pkg::LeaveByte2;
            n_len      = 4'd3;
        end
        if (i_cmd.n_data != 2'd0) begin
            n_bytes[n_len[2:0]] = i_cmd.data0;
            n_len               = n_len + 4'd1;
        end
        if (i_cmd.n_data == 2'd2) begin
            n_bytes[n_len[2:0]] = i_cmd.data1;
            n_len               = n_len + 4'd1;
        end
        if (i_cmd.post_leave) begin
            n_bytes[n_len[2:0]]        = sjis_pkg::EscByte;
            n_bytes[n_len[2:0] + 3'd1] = sjis_pkg::LeaveByte1;
            n_bytes[n_len[2:0] + 3'd2] = sjis_pkg::LeaveByte2;
            n_len                      = n_len + 4'd3;
        end
    end

    assign advance = r_busy && (!r_out_valid || !i_stall);
    assign at_last = ({1'b0, r_pos} == (r_len - 4'd1));
    assign load    = i_cmd_valid && (!r_busy || (advance && at_last));
    assign o_pop   = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_pos  <= 3'd0;
            end else if (advance) begin
                r_busy <= !at_last;
                r_pos  <= r_pos + 3'd1;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= n_bytes;
            r_len   <= n_len;
        end
        if (advance) begin
            r_out_byte <= r_bytes[r_pos];
            r_out_last <= at_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule

// ===== sv/shift_jis_to_jis_stream_core.sv =====
// Top level of the Shift-JIS to 7-bit JIS stream converter.
// Depends on sjis_pkg, sjis_front, sjis_queue and sjis_back.
//
//   Channel  Direction  Handshake            Payload
//   input    in         i_valid / o_stall    i_data_byte[7:0], i_end_of_text
//   output   out        o_valid / i_stall    o_out_byte[7:0], o_last_of_run
//
// An input byte is classified in the cycle it is accepted; the output
// channel then carries one byte per cycle while the receiver does not stall,
// and an input causes zero to eight output bytes. A run reaches the output
// after its command is loaded into the back byte buffer and its first byte
// into the output register. Reset is synchronous and active low; it returns
// to ASCII mode with nothing held. Input stalls only when the queue is full.
module shift_jis_to_jis_stream_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    logic           in_accept;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_nonempty;
    sjis_pkg::t_cmd front_cmd;
    sjis_pkg::t_cmd head_cmd;

    // The stall comes from the queue count register alone, so it never
    // depends on the input valid.
    assign o_stall   = q_full;
    assign in_accept = i_valid && !q_full;

    // The front keeps the mode flag and the held lead byte and turns every
    // transfer into at most one command.
    sjis_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    // The queue lets the front keep taking bytes while a long run of
    // escape and data bytes drains on the output side.
    sjis_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (front_cmd),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head_cmd)
    );

    // The back expands each command and owns the output register, loading
    // the next command on the same cycle the last byte of the previous one
    // moves out.
    sjis_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_nonempty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== tb/sv/sjis_stream_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Shift-JIS to JIS stream converter: watches both channels,
// predicts the JIS bytes of every accepted input byte and compares them.
// Depends on nothing but the channel signals of the converter.
module sjis_stream_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_sjis_byte,
    input  logic       i_end_of_text,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_jis_byte,
    input  logic       i_last_of_run,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_jis_out;

    // Full-width JIS codes for the half-width kana, indexed by byte - 0xA0.
    localparam logic [15:0] FullWidthKana [64] = '{
        16'h2121, 16'h2123, 16'h2156, 16'h2157, 16'h2122, 16'h2126,
        16'h2572, 16'h2521, 16'h2523, 16'h2525, 16'h2527, 16'h2529,
        16'h2563, 16'h2565, 16'h2567, 16'h2543, 16'h213c, 16'h2522,
        16'h2524, 16'h2526, 16'h2528, 16'h252a, 16'h252b, 16'h252d,
        16'h252f, 16'h2531, 16'h2533, 16'h2535, 16'h2537, 16'h2539,
        16'h253b, 16'h253d, 16'h253f, 16'h2541, 16'h2544, 16'h2546,
        16'h2548, 16'h254a, 16'h254b, 16'h254c, 16'h254d, 16'h254e,
        16'h254f, 16'h2552, 16'h2555, 16'h2558, 16'h255b, 16'h255e,
        16'h255f, 16'h2560, 16'h2561, 16'h2562, 16'h2564, 16'h2566,
        16'h2568, 16'h2569, 16'h256a, 16'h256b, 16'h256c, 16'h256d,
        16'h256f, 16'h2573, 16'h212b, 16'h212c
    };

    localparam logic [7:0] EscCode = 8'h1B;

    logic       double_mode;
    logic [7:0] waiting_lead;
    logic       lead_waiting;
    logic [7:0] jis_run [$];
    t_jis_out   expected_jis [$];
    int         fail_count;
    int         checked_count;

    function automatic logic is_lead(input logic [7:0] b);
        return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
    endfunction

    function automatic logic is_trail(input logic [7:0] b);
        return (b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC);
    endfunction

    task automatic open_double_mode();
        if (!double_mode) begin
            double_mode = 1'b1;
            jis_run.push_back(EscCode);
            jis_run.push_back(8'h24);
            jis_run.push_back(8'h42);
        end
    endtask

    task automatic close_double_mode();
        if (double_mode) begin
            double_mode = 1'b0;
            jis_run.push_back(EscCode);
            jis_run.push_back(8'h28);
            jis_run.push_back(8'h4A);
        end
    endtask

    // A byte that does not complete a held lead byte.
    task automatic convert_single(input logic [7:0] b);
        logic [15:0] kana;
        if (is_lead(b)) begin
            waiting_lead = b;
            lead_waiting = 1'b1;
        end else if (b >= 8'hA1 && b <= 8'hDF) begin
            kana = FullWidthKana[6'(b - 8'hA0)];
            open_double_mode();
            jis_run.push_back(kana[15:8]);
            jis_run.push_back(kana[7:0]);
        end else if (!b[7]) begin
            close_double_mode();
            jis_run.push_back(b);
        end
    endtask

    task automatic predict_jis(input logic [7:0] b, input logic eot);
        logic [7:0] lead;
        logic [7:0] hi;
        logic [7:0] lo;
        jis_run = {};
        if (lead_waiting) begin
            lead = waiting_lead;
            lead_waiting = 1'b0;
            waiting_lead = 8'h00;
            if (is_trail(b)) begin
                // Pair arithmetic is done in 8 bits; for the user-defined lead range the
                // JIS lead byte comes out above 0x7E.
                hi = lead - ((lead <= 8'h9F) ? 8'h71 : 8'hB1);
                hi = hi * 8'd2 + 8'd1;
                lo = (b > 8'h7F) ? b - 8'd1 : b;
                if (lo >= 8'h9E) begin
                    lo = lo - 8'h7D;
                    hi = hi + 8'd1;
                end else begin
                    lo = lo - 8'h1F;
                end
                open_double_mode();
                jis_run.push_back(hi);
                jis_run.push_back(lo);
            end else begin
                convert_single(b);
            end
        end else begin
            convert_single(b);
        end
        if (eot) begin
            lead_waiting = 1'b0;
            waiting_lead = 8'h00;
            close_double_mode();
        end
        foreach (jis_run[i])
            expected_jis.push_back('{code: jis_run[i], last: (i == jis_run.size() - 1)});
    endtask

    always @(posedge i_clk) begin
        t_jis_out want;
        if (!i_rst_n) begin
            double_mode = 1'b0;
            waiting_lead = 8'h00;
            lead_waiting = 1'b0;
            expected_jis = {};
        end else begin
            if (i_out_valid && !i_out_stall) begin
                checked_count++;
                if (expected_jis.size() == 0) begin
                    $error("unexpected JIS byte %02h (last %0b)", i_jis_byte, i_last_of_run);
                    fail_count++;
                end else begin
                    want = expected_jis.pop_front();
                    if (i_jis_byte !== want.code) begin
                        $error("out_byte: expected %02h, got %02h", want.code, i_jis_byte);
                        fail_count++;
                    end
                    if (i_last_of_run !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last, i_last_of_run);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_jis(i_sjis_byte, i_end_of_text);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_jis.size();
        o_checked    <= checked_count;
    end

    initial begin
        fail_count    = 0;
        checked_count = 0;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, directed and random
// Shift-JIS stimulus, output stalls and the verdict.
// Depends on shift_jis_to_jis_stream_core and sjis_stream_checker.
module testbench;

    localparam int RandomItems = 310;
    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 16;

    // Kinds of random text fragment.
    typedef enum int {
        FRAG_ASCII,
        FRAG_KANA,
        FRAG_PAIR,
        FRAG_BROKEN,
        FRAG_DROP
    } t_frag_kind;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_data_byte   = 8'h20;
    logic       i_end_of_text = 1'b0;
    logic       i_stall       = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;

    int fail_count;
    int pending_jis;
    int checked_jis;
    int bytes_sent    = 0;
    int burst_left    = 0;
    bit steady_sender = 1'b0;
    int cycle_count   = 0;
    int stall_mode    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    shift_jis_to_jis_stream_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    sjis_stream_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_sjis_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_jis_byte    (o_out_byte),
        .i_last_of_run (o_last_of_run),
        .o_fail_count  (fail_count),
        .o_pending     (pending_jis),
        .o_checked     (checked_jis)
    );

    // The receiver moves between three modes picked at random: never stalling,
    // stalling at random and a fixed repeating stall pattern.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 64 == 0)
            stall_mode <= $urandom_range(0, 2);
        if (!i_rst_n)
            i_stall <= 1'b0;
        else if (stall_mode == 0)
            i_stall <= 1'b0;
        else if (stall_mode == 1)
            i_stall <= ($urandom_range(0, 9) < 3);
        else
            i_stall <= (cycle_count % 7) < 4;
        if (cycle_count == CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sends one byte as a single transfer. Bytes go out in bursts of random
    // length; between bursts the valid line drops for a random gap, except
    // in steady stretches where the sender keeps valid high throughout.
    task automatic send_sjis(input logic [7:0] b, input logic eot);
        int gap;
        if (bytes_sent % 48 == 0)
            steady_sender = ($urandom_range(0, 3) == 0);
        if (burst_left == 0) begin
            gap = steady_sender ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    initial begin
        t_frag_kind kind;
        logic [7:0] lead;
        logic [7:0] tail;
        int         pick;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. ASCII extremes, kana at both ends of the range, the
        // dropped high bytes, then pairs at the corners of the lead and trail
        // ranges, including a user-defined lead whose JIS lead byte is above 0x7E.
        send_sjis(8'h41, 1'b0);
        send_sjis(8'h01, 1'b0);
        send_sjis(8'h7F, 1'b0);
        send_sjis(8'hA1, 1'b0);
        send_sjis(8'hDF, 1'b0);
        send_sjis(8'h80, 1'b0);
        send_sjis(8'hA0, 1'b0);
        send_sjis(8'hFD, 1'b0);
        send_sjis(8'hFE, 1'b0);
        send_sjis(8'hFF, 1'b0);
        send_sjis(8'h81, 1'b0);
        send_sjis(8'h40, 1'b0);
        send_sjis(8'h9F, 1'b0);
        send_sjis(8'hFC, 1'b0);
        send_sjis(8'hE0, 1'b0);
        send_sjis(8'h7E, 1'b0);
        send_sjis(8'hFC, 1'b0);
        // End of text on the trail byte of a pair closes the open JIS mode.
        send_sjis(8'h80, 1'b1);
        // A held lead followed by a byte that cannot be a trail: the lead is
        // dropped and the new byte is handled on its own.
        send_sjis(8'h81, 1'b0);
        send_sjis(8'h3F, 1'b0);
        send_sjis(8'hE5, 1'b0);
        send_sjis(8'hFD, 1'b0);
        // End of text while a lead is held in JIS mode: only the closing
        // escape comes out.
        send_sjis(8'hB0, 1'b0);
        send_sjis(8'h90, 1'b1);
        send_sjis(8'h41, 1'b1);
        // A pair opened and closed by a single byte: the longest run.
        send_sjis(8'h82, 1'b0);
        send_sjis(8'hA5, 1'b1);

        // Random part: mostly well-formed text with random content, the rest
        // broken pairs and bytes that are simply dropped.
        while (bytes_sent < RandomItems + 27) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                kind = FRAG_ASCII;
            else if (pick < 50)
                kind = FRAG_KANA;
            else if (pick < 78)
                kind = FRAG_PAIR;
            else if (pick < 90)
                kind = FRAG_BROKEN;
            else
                kind = FRAG_DROP;

            lead = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h81, 8'h9F))
                                                : 8'($urandom_range(8'hE0, 8'hFC));
            case (kind)
                FRAG_ASCII: begin
                    send_sjis(8'($urandom_range(8'h01, 8'h7F)), $urandom_range(0, 15) == 0);
                end
                FRAG_KANA: begin
                    send_sjis(8'($urandom_range(8'hA1, 8'hDF)), $urandom_range(0, 15) == 0);
                end
                FRAG_PAIR: begin
                    tail = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(8'h40, 8'h7E))
                                                        : 8'($urandom_range(8'h80, 8'hFC));
                    send_sjis(lead, 1'b0);
                    send_sjis(tail, $urandom_range(0, 15) == 0);
                end
                FRAG_BROKEN: begin
                    pick = $urandom_range(0, 3);
                    if (pick == 0) begin
                        // The text ends on the lead byte itself.
                        send_sjis(lead, 1'b1);
                    end else begin
                        if (pick == 1)
                            tail = 8'($urandom_range(8'h01, 8'h3F));
                        else if (pick == 2)
                            tail = 8'h7F;
                        else
                            tail = 8'($urandom_range(8'hFD, 8'hFF));
                        send_sjis(lead, 1'b0);
                        send_sjis(tail, $urandom_range(0, 15) == 0);
                    end
                end
                default: begin
                    pick = $urandom_range(0, 4);
                    tail = (pick == 0) ? 8'h80 : (pick == 1) ? 8'hA0
                                                   : 8'($urandom_range(8'hFD, 8'hFF));
                    send_sjis(tail, $urandom_range(0, 15) == 0);
                end
            endcase
        end
        i_valid <= 1'b0;

        // Let the converter drain; the cycle counter catches a hang. The
        // pending count is registered in the checker, so wait for the next edge first.
        @(posedge i_clk);
        while (pending_jis != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Sent %0d Shift-JIS bytes (ASCII, kana, pairs, broken pairs, dropped bytes),",
                 bytes_sent);
        $display("checked %0d JIS bytes under random sender gaps and receiver stalls.",
                 checked_jis);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sjis_pkg.sv
sv/sjis_front.sv
sv/sjis_queue.sv
sv/sjis_back.sv
sv/shift_jis_to_jis_stream_core.sv
tb/sv/sjis_stream_checker.sv
tb/sv/testbench.sv
